### hw/rtl/pca_pkg.sv
package pca_pkg;
    localparam int AreaW   = 44;
    localparam int MomW    = 61;
    localparam int CenW    = 24;
    localparam int CoordW  = 16;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FEW   = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;
    localparam logic [1:0] ST_MANY  = 2'd3;

    // closed polygon handed from front to back end
    typedef struct packed {
        logic [1:0]               status;
        logic signed [AreaW-1:0]  area;
        logic signed [MomW-1:0]   mom_x;
        logic signed [MomW-1:0]   mom_y;
    } t_poly;
endpackage

### hw/rtl/pca_front.sv
module pca_front #(
    parameter int MAX_VERTICES = 1024,
    parameter int COORD_WIDTH  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [pca_pkg::CoordW-1:0] i_x,
    input  logic signed [pca_pkg::CoordW-1:0] i_y,
    input  logic                          i_last,
    output logic                          o_stall,
    output logic                          o_valid,
    output pca_pkg::t_poly                o_poly,
    input  logic                          i_q_full
);
    import pca_pkg::*;

    localparam int CntW = $clog2(MAX_VERTICES + 2);
    localparam int CW = COORD_WIDTH;
    localparam int PW = 2 * CW + 2;

    // two-stage: stage 1 forms edge products, stage 2 accumulates moments
    logic signed [CW-1:0] r_fx, r_fy, r_px, r_py;
    logic [CntW-1:0] r_cnt;

    // stage 1 registers
    logic                 r_s1_v, r_s1_edge, r_s1_last, r_s1_many, r_s1_few;
    logic signed [PW-1:0] r_s1_a;
    logic signed [CW:0]   r_s1_sx, r_s1_sy;
    logic signed [PW-1:0] r_s1_a2;
    logic signed [CW:0]   r_s1_sx2, r_s1_sy2;

    // stage 2
    logic                 r_s2_v, r_s2_last, r_s2_many, r_s2_few;
    logic signed [AreaW-1:0] r_area;
    logic signed [MomW-1:0]  r_mx, r_my;

    logic signed [CW-1:0] w_x, w_y;
    logic w_acc, w_stall;

    assign w_x = i_x[CW-1:0];
    assign w_y = i_y[CW-1:0];
    assign w_acc = (r_cnt < CntW'(MAX_VERTICES));
    // closing result must wait for queue room
    assign w_stall = i_q_full && (r_s1_v && r_s1_last || r_s2_v && r_s2_last);
    assign o_stall = w_stall;

    // first vertex after this one is taken in
    logic signed [CW-1:0] w_cx0, w_cy0;
    assign w_cx0 = (w_acc && r_cnt == '0) ? w_x : r_fx;
    assign w_cy0 = (w_acc && r_cnt == '0) ? w_y : r_fy;
    logic signed [CW-1:0] w_lx, w_ly;
    assign w_lx = w_acc ? w_x : r_px;
    assign w_ly = w_acc ? w_y : r_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_fx <= '0; r_fy <= '0; r_px <= '0; r_py <= '0;
        end else if (!w_stall) begin
            r_s1_v <= i_valid;
            if (i_valid) begin
                r_s1_edge <= w_acc && (r_cnt != '0);
                r_s1_a  <= PW'(r_px * w_y) - PW'(w_x * r_py);
                r_s1_sx <= (CW+1)'(r_px) + (CW+1)'(w_x);
                r_s1_sy <= (CW+1)'(r_py) + (CW+1)'(w_y);
                r_s1_a2  <= PW'(w_lx * w_cy0) - PW'(w_cx0 * w_ly);
                r_s1_sx2 <= (CW+1)'(w_lx) + (CW+1)'(w_cx0);
                r_s1_sy2 <= (CW+1)'(w_ly) + (CW+1)'(w_cy0);
                r_s1_last <= i_last;
                r_s1_many <= !w_acc;
                r_s1_few  <= w_acc && (r_cnt < CntW'(2));
                if (w_acc) begin
                    if (r_cnt == '0) begin
                        r_fx <= w_x; r_fy <= w_y;
                    end
                    r_px <= w_x; r_py <= w_y;
                end
                if (i_last) begin
                    r_cnt <= '0;
                end else if (w_acc) begin
                    r_cnt <= r_cnt + 1'b1;
                end else begin
                    r_cnt <= CntW'(MAX_VERTICES + 1);
                end
            end
            r_s2_v <= r_s1_v && r_s1_last;
            if (r_s1_v) begin
                r_s2_last <= r_s1_last;
                r_s2_many <= r_s1_many;
                r_s2_few  <= r_s1_few;
            end
        end
    end

    // accumulators: first add on edge, closing edge on last
    logic signed [AreaW-1:0] w_area_base, n_area;
    logic signed [MomW-1:0]  w_mx_base, w_my_base, n_mx, n_my;
    logic signed [PW-1:0]    w_a1, w_a2;
    logic signed [PW+CW:0]   w_px1, w_px2, w_py1, w_py2;
    always_comb begin
        w_area_base = (r_s2_v && r_s2_last) ? '0 : r_area;
        w_mx_base   = (r_s2_v && r_s2_last) ? '0 : r_mx;
        w_my_base   = (r_s2_v && r_s2_last) ? '0 : r_my;
        w_a1 = r_s1_edge ? r_s1_a : '0;
        w_a2 = (r_s1_last && !r_s1_many) ? r_s1_a2 : '0;
        w_px1 = r_s1_sx * w_a1;
        w_px2 = r_s1_sx2 * w_a2;
        w_py1 = r_s1_sy * w_a1;
        w_py2 = r_s1_sy2 * w_a2;
        n_area = w_area_base + AreaW'(w_a1) + AreaW'(w_a2);
        n_mx = w_mx_base + MomW'(w_px1) + MomW'(w_px2);
        n_my = w_my_base + MomW'(w_py1) + MomW'(w_py2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area <= '0; r_mx <= '0; r_my <= '0;
        end else if (!w_stall) begin
            if (r_s1_v) begin
                r_area <= n_area; r_mx <= n_mx; r_my <= n_my;
            end else if (r_s2_v && r_s2_last) begin
                r_area <= '0; r_mx <= '0; r_my <= '0;
            end
        end
    end

    assign o_valid = r_s2_v && r_s2_last && !i_q_full;
    always_comb begin
        o_poly.area  = r_area;
        o_poly.mom_x = r_mx;
        o_poly.mom_y = r_my;
        if (r_s2_many)           o_poly.status = ST_MANY;
        else if (r_s2_few)       o_poly.status = ST_FEW;
        else if (r_area == '0)   o_poly.status = ST_ZERO;
        else                     o_poly.status = ST_OK;
    end
endmodule

### hw/rtl/pca_queue.sv
module pca_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pca_pkg::t_poly i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output pca_pkg::t_poly o_data
);
    import pca_pkg::*;
    t_poly r_mem [2];
    logic  r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_push && !o_full) r_wp <= ~r_wp;
            if (i_pop && !o_empty) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'((i_push && !o_full) ? 1 : 0)
                           - 2'((i_pop && !o_empty) ? 1 : 0);
        end
    end
endmodule

### hw/rtl/pca_back.sv
module pca_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  pca_pkg::t_poly i_poly,
    output logic           o_pop,
    output logic           o_empty,
    input  logic           i_pop,
    output logic [1:0]     o_status,
    output logic signed [pca_pkg::AreaW-1:0] o_twice_area,
    output logic signed [pca_pkg::CenW-1:0]  o_centroid_x,
    output logic signed [pca_pkg::CenW-1:0]  o_centroid_y
);
    import pca_pkg::*;

    // restoring division of |m|*256 by |3a|, both axes in parallel, one bit a cycle
    localparam int NW = MomW + 8;
    localparam int DW = AreaW + 2;
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] r_state;
    logic [6:0] r_step;
    logic [NW-1:0] r_qx, r_qy;
    logic [DW:0]   r_rx, r_ry;
    logic [DW-1:0] r_d;
    logic r_negx, r_negy;
    logic [1:0] r_st;
    logic signed [AreaW-1:0] r_area;

    logic [MomW-1:0] w_mx_abs, w_my_abs;
    logic signed [DW-1:0] w_d3;
    assign w_mx_abs = i_poly.mom_x[MomW-1] ? MomW'(-i_poly.mom_x) : i_poly.mom_x;
    assign w_my_abs = i_poly.mom_y[MomW-1] ? MomW'(-i_poly.mom_y) : i_poly.mom_y;
    assign w_d3 = DW'(i_poly.area) + (DW'(i_poly.area) <<< 1);

    logic [DW:0] w_tx, w_ty;
    assign w_tx = {r_rx[DW-1:0], r_qx[NW-1]};
    assign w_ty = {r_ry[DW-1:0], r_qy[NW-1]};

    assign o_pop = (r_state == S_IDLE) && !i_empty;
    assign o_empty = (r_state != S_OUT);

    function automatic logic signed [CenW-1:0] sat(input logic [NW-1:0] q, input logic neg);
        logic [NW:0] lim;
        begin
            lim = neg ? (NW+1)'(24'h800000) : (NW+1)'(24'h7fffff);
            if ({1'b0, q} > lim) sat = neg ? CenW'(24'h800000) : CenW'(24'h7fffff);
            else                 sat = neg ? CenW'(-q[CenW-1:0]) : q[CenW-1:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_st   <= i_poly.status;
                        r_area <= (i_poly.status == ST_OK) ? i_poly.area : '0;
                        r_qx <= {w_mx_abs, 8'd0};
                        r_qy <= {w_my_abs, 8'd0};
                        r_rx <= '0; r_ry <= '0;
                        r_d  <= w_d3[DW-1] ? DW'(-w_d3) : w_d3;
                        r_negx <= i_poly.mom_x[MomW-1] ^ w_d3[DW-1];
                        r_negy <= i_poly.mom_y[MomW-1] ^ w_d3[DW-1];
                        r_step <= 7'(NW);
                        r_state <= (i_poly.status == ST_OK) ? S_DIV : S_OUT;
                    end
                end
                S_DIV: begin
                    if (w_tx >= {1'b0, r_d}) begin
                        r_rx <= w_tx - {1'b0, r_d}; r_qx <= {r_qx[NW-2:0], 1'b1};
                    end else begin
                        r_rx <= w_tx; r_qx <= {r_qx[NW-2:0], 1'b0};
                    end
                    if (w_ty >= {1'b0, r_d}) begin
                        r_ry <= w_ty - {1'b0, r_d}; r_qy <= {r_qy[NW-2:0], 1'b1};
                    end else begin
                        r_ry <= w_ty; r_qy <= {r_qy[NW-2:0], 1'b0};
                    end
                    r_step <= r_step - 7'd1;
                    if (r_step == 7'd1) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_pop) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_status     = r_st;
    assign o_twice_area = r_area;
    assign o_centroid_x = (r_st == ST_OK) ? sat(r_qx, r_negx) : '0;
    assign o_centroid_y = (r_st == ST_OK) ? sat(r_qy, r_negy) : '0;
endmodule

### hw/rtl/polygon_centroid_area.sv
// channel | direction | handshake     | payload
// vertex  | in        | push / full   | vertex_x, vertex_y, last_vertex
// result  | out       | pop / empty   | status, twice_area, centroid_x, centroid_y
//
// front end takes one vertex per cycle while full is low; two registered
//   steps (edge products, moment accumulate) before a closed polygon enters a two-entry queue
// back end loads a polygon in S_IDLE, runs a bit-serial divider (one quotient
//   bit per cycle, both axes together) and holds the result in S_OUT until
//   popped; flagged polygons skip the divider
// synchronous active-low reset clears counters, accumulators and queue pointers
// full rises only while a closing vertex waits for queue room
module polygon_centroid_area #(
    parameter int MAX_VERTICES = 1024,
    parameter int COORD_WIDTH  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic signed [15:0] i_vertex_x,
    input  logic signed [15:0] i_vertex_y,
    input  logic        i_last_vertex,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic signed [43:0] o_twice_area,
    output logic signed [23:0] o_centroid_x,
    output logic signed [23:0] o_centroid_y
);
    import pca_pkg::*;

    logic  w_fv, w_qfull, w_qempty, w_qpop;
    t_poly w_fpoly, w_qpoly;

    // front: vertex accumulation
    pca_front #(.MAX_VERTICES(MAX_VERTICES), .COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(push && !full), .i_x(i_vertex_x), .i_y(i_vertex_y),
        .i_last(i_last_vertex), .o_stall(full),
        .o_valid(w_fv), .o_poly(w_fpoly), .i_q_full(w_qfull)
    );

    // decoupling queue between front and divider
    pca_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_fv), .i_data(w_fpoly), .o_full(w_qfull),
        .i_pop(w_qpop), .o_empty(w_qempty), .o_data(w_qpoly)
    );

    // back: centroid divide and result hold
    pca_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_empty(w_qempty), .i_poly(w_qpoly), .o_pop(w_qpop),
        .o_empty(empty), .i_pop(pop),
        .o_status(o_status), .o_twice_area(o_twice_area),
        .o_centroid_x(o_centroid_x), .o_centroid_y(o_centroid_y)
    );
endmodule

### hw/rtl/pca_check.sv
module pca_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  o_status,
    input logic signed [43:0] o_twice_area,
    input logic signed [23:0] o_centroid_x
);
    import pca_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_twice_area))
        else $error("result changed while waiting");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_status != ST_OK |-> o_twice_area == '0 && o_centroid_x == '0)
        else $error("flagged result not zero");
    a_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_status == ST_OK |-> o_twice_area != '0)
        else $error("ok result with zero area");
endmodule

bind polygon_centroid_area pca_check u_check (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .empty(empty), .pop(pop),
    .o_status(o_status), .o_twice_area(o_twice_area), .o_centroid_x(o_centroid_x)
);
